// ----- design/jts_pkg.sv -----
// ----------------------------------------------------------------------------
// jts_pkg: shared types and constants of the json token splitter
// request payload structs, token type codes and the special characters
// ----------------------------------------------------------------------------
package jts_pkg;

  // token type codes
  localparam logic [1:0] TypeString = 2'd0;
  localparam logic [1:0] TypeNumber = 2'd1;
  localparam logic [1:0] TypeSymbol = 2'd2;

  // request action codes
  localparam logic ActByte = 1'b0;
  localparam logic ActEnd  = 1'b1;

  // result kind codes
  localparam logic KindByte = 1'b0;
  localparam logic KindEnd  = 1'b1;

  // special characters
  localparam logic [7:0] ChCr     = 8'd13;
  localparam logic [7:0] ChLf     = 8'd10;
  localparam logic [7:0] ChTab    = 8'd9;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChMinus  = 8'h2d;
  localparam logic [7:0] ChDot    = 8'h2e;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChLBrace = 8'h7b;
  localparam logic [7:0] ChRBrace = 8'h7d;
  localparam logic [7:0] ChLBrack = 8'h5b;
  localparam logic [7:0] ChRBrack = 8'h5d;
  localparam logic [7:0] ChComma  = 8'h2c;
  localparam logic [7:0] ChColon  = 8'h3a;

  typedef struct packed {
    logic       action;
    logic [7:0] char_in;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_out;
    logic [1:0] token_type;
    logic       token_empty;
  } out_t;

endpackage

// ----- design/json_token_splitter.sv -----
// ----------------------------------------------------------------------------
// json_token_splitter: byte-serial json lexer
// cuts a document byte stream into tokens, up to one request byte per cycle
// ----------------------------------------------------------------------------
// order: with the result queue empty, a request's first result is on out_o in
//   the cycle after the request is taken, and a second result follows it;
//   results already queued ahead are put out first
// throughput: one request per cycle while each yields at most one result and
//   out_ready_i is high; the output drains one result per cycle, so two-result
//   requests are held back (in_ready_o drops with more than two queued)
// reset: asynchronous, clears lexer state and empties the result queue
module json_token_splitter
  import jts_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  localparam int unsigned QDepth = 4;
  localparam int unsigned PtrW   = $clog2(QDepth);
  localparam int unsigned CntW   = $clog2(QDepth + 1);

  // lexer state
  logic       in_quotes_q, in_quotes_d;
  logic       esc_q, esc_d;
  logic [7:0] prev_q, prev_d;
  logic [1:0] type_q, type_d;
  logic       has_q, has_d;

  // result queue
  out_t            queue_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  logic       in_fire, out_fire;
  logic [1:0] push_n;
  out_t       res0, res1;

  logic [7:0] c;
  logic       c_num, prev_num, c_space, c_delim, esc_tog, tok_end;

  assign c = in_i.char_in;

  // character classes
  assign c_num    = ((c >= ChZero) && (c <= ChNine)) || (c == ChMinus) || (c == ChDot);
  assign prev_num = ((prev_q >= ChZero) && (prev_q <= ChNine)) ||
                    (prev_q == ChMinus) || (prev_q == ChDot);
  assign c_space  = (c == ChSpace) || (c == ChTab) || (c == ChCr) || (c == ChLf);
  assign c_delim  = (c == ChQuote) || (c == ChLBrace) || (c == ChRBrace) ||
                    (c == ChLBrack) || (c == ChRBrack) || (c == ChComma) ||
                    (c == ChColon);

  // escape flag after a possible backslash toggle
  assign esc_tog = (c == ChBslash) ? ~esc_q : esc_q;
  // previous token closes before this byte
  assign tok_end = (c_delim || (c_num && !prev_num)) && has_q;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  // room for two results is needed before a request is taken
  assign in_ready_o  = (count_q <= CntW'(QDepth - 2));
  assign out_valid_o = (count_q != '0);
  assign out_o       = queue_q[rd_ptr_q];

  // per-byte lexing
  always_comb begin
    in_quotes_d = in_quotes_q;
    esc_d       = esc_q;
    prev_d      = prev_q;
    type_d      = type_q;
    has_d       = has_q;
    push_n      = 2'd0;
    res0        = '0;
    res1        = '0;

    if (in_i.action == ActEnd) begin
      // close the final token, even when empty, then restart the document
      res0.kind        = KindEnd;
      res0.token_type  = type_q;
      res0.token_empty = ~has_q;
      push_n           = 2'd1;
      in_quotes_d      = 1'b0;
      esc_d            = 1'b0;
      prev_d           = '0;
      type_d           = TypeSymbol;
      has_d            = 1'b0;
    end else begin
      prev_d = c;
      if (in_quotes_q) begin
        // every quoted byte is kept; an unescaped quote closes the string
        if ((c == ChQuote) && !esc_tog) begin
          in_quotes_d = 1'b0;
        end
        esc_d          = esc_tog && (c == ChBslash);
        has_d          = 1'b1;
        res0.kind      = KindByte;
        res0.char_out  = c;
        res0.token_type = type_q;
        push_n         = 2'd1;
      end else if (!c_space) begin
        if (c == ChQuote) begin
          type_d      = TypeString;
          in_quotes_d = 1'b1;
        end else if (c_num) begin
          type_d = TypeNumber;
        end else begin
          // letters and other bytes join the previous token as a symbol
          type_d = TypeSymbol;
        end
        has_d = 1'b1;
        if (tok_end) begin
          res0.kind        = KindEnd;
          res0.token_type  = type_q;
          res1.kind        = KindByte;
          res1.char_out    = c;
          res1.token_type  = type_d;
          push_n           = 2'd2;
        end else begin
          res0.kind       = KindByte;
          res0.char_out   = c;
          res0.token_type = type_d;
          push_n          = 2'd1;
        end
      end
    end
  end

  // lexer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_quotes_q <= 1'b0;
      esc_q       <= 1'b0;
      prev_q      <= '0;
      type_q      <= TypeSymbol;
      has_q       <= 1'b0;
    end else if (in_fire) begin
      in_quotes_q <= in_quotes_d;
      esc_q       <= esc_d;
      prev_q      <= prev_d;
      type_q      <= type_d;
      has_q       <= has_d;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + (in_fire ? CntW'(push_n) : CntW'(0))
                         - (out_fire ? CntW'(1) : CntW'(0));
    end
  end

  // queue storage, payload only
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (push_n != 2'd0) begin
        queue_q[wr_ptr_q] <= res0;
      end
      if (push_n == 2'd2) begin
        queue_q[wr_ptr_q + PtrW'(1)] <= res1;
      end
    end
  end

endmodule

// ----- tb/sv/json_token_splitter_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_token_splitter_checker: result predictor and scoreboard
// watches both channels of the token splitter, lexes every accepted request
// on its own copy of the lexer state and compares each result field by field
// ----------------------------------------------------------------------------
module json_token_splitter_checker
  import jts_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_i,
  output int   fail_count_o,
  output int   pending_o
);

  // lexer state as seen by the predictor
  logic       in_str;
  logic       esc_pend;
  logic [7:0] last_byte;
  logic [1:0] tok_type;
  logic       tok_filled;

  out_t pending_tokens[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic void clear_lexer();
    in_str     = 1'b0;
    esc_pend   = 1'b0;
    last_byte  = 8'h00;
    tok_type   = TypeSymbol;
    tok_filled = 1'b0;
  endfunction

  function automatic out_t make_result(logic k, logic [7:0] ch, logic [1:0] ty, logic em);
    out_t r;
    r.kind        = k;
    r.char_out    = ch;
    r.token_type  = ty;
    r.token_empty = em;
    return r;
  endfunction

  function automatic logic is_num(logic [7:0] c);
    return (c >= ChZero && c <= ChNine) || c == ChMinus || c == ChDot;
  endfunction

  // lex one request and queue the results it causes
  function automatic void lex_byte(in_t req);
    logic [7:0] c;
    logic [7:0] prev;
    logic       is_ws;
    logic       is_delim;
    c = req.char_in;
    if (req.action == ActEnd) begin
      pending_tokens.push_back(make_result(KindEnd, 8'h00, tok_type, !tok_filled));
      clear_lexer();
      return;
    end
    prev      = last_byte;
    last_byte = c;
    if (in_str) begin
      if (c == ChBslash) esc_pend = !esc_pend;
      if (c == ChQuote && !esc_pend) in_str = 1'b0;
      if (esc_pend && c != ChBslash) esc_pend = 1'b0;
      tok_filled = 1'b1;
      pending_tokens.push_back(make_result(KindByte, c, tok_type, 1'b0));
      return;
    end
    is_ws = (c == ChSpace) || (c == ChTab) || (c == ChCr) || (c == ChLf);
    if (is_ws) return;
    is_delim = (c == ChQuote) || (c == ChLBrace) || (c == ChRBrace) || (c == ChLBrack) ||
               (c == ChRBrack) || (c == ChComma) || (c == ChColon);
    if ((is_delim || (is_num(c) && !is_num(prev))) && tok_filled) begin
      pending_tokens.push_back(make_result(KindEnd, 8'h00, tok_type, 1'b0));
      tok_filled = 1'b0;
    end
    if (c == ChQuote) begin
      tok_type = TypeString;
      in_str   = 1'b1;
    end else if (is_num(c)) begin
      tok_type = TypeNumber;
    end else begin
      tok_type = TypeSymbol;
    end
    tok_filled = 1'b1;
    pending_tokens.push_back(make_result(KindByte, c, tok_type, 1'b0));
  endfunction

  function automatic logic field_ok(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin
    out_t exp_r;
    logic ok;
    if (!rst_ni) begin
      clear_lexer();
      pending_tokens.delete();
    end else begin
      // results first: a request never yields a result at its own edge
      if (out_valid_i && out_ready_i) begin
        if (pending_tokens.size() == 0) begin
          $display("%0t ns: unexpected result, expected none actual %0h", $time, out_i);
          fail_count_o = fail_count_o + 1;
        end else begin
          exp_r = pending_tokens.pop_front();
          ok = field_ok("kind", exp_r.kind, out_i.kind);
          ok = field_ok("char_out", exp_r.char_out, out_i.char_out) && ok;
          ok = field_ok("token_type", exp_r.token_type, out_i.token_type) && ok;
          ok = field_ok("token_empty", exp_r.token_empty, out_i.token_empty) && ok;
          if (!ok) fail_count_o = fail_count_o + 1;
        end
      end
      if (in_valid_i && in_ready_i) lex_byte(in_i);
    end
    pending_o = pending_tokens.size();
  end

endmodule

// ----- tb/sv/json_token_splitter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_token_splitter_tb: regression top for the json token splitter
// drives a directed document and then random json-like fragments through the
// request channel under three idling mixes, while the checker scores results
// ----------------------------------------------------------------------------
module json_token_splitter_tb;
  import jts_pkg::*;

  // generous bound on the whole run, far above the slowest legal run
  localparam int CycleLimit = 200000;
  // items per random phase
  localparam int PhaseItems = 217;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_req;
  logic out_valid;
  logic out_ready;
  out_t out_res;

  int fail_count;
  int pending;
  int cycle_cnt;
  int sent_cnt;
  // idle percentages of sender and receiver, set per phase
  int send_idle_pct;
  int recv_idle_pct;

  json_token_splitter DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_res)
  );

  json_token_splitter_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_i        (in_req),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_i       (out_res),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog on the cycle count
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t ns: timeout with %0d results outstanding", $time, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: ready toggles at random on each falling edge
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // hand one request over: random idle cycles, then hold valid until taken
  task automatic send_req(input logic act, input logic [7:0] ch);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= '{action: act, char_in: ch};
    // in_ready sampled at the rising edge, before the block updates
    do @(posedge clk); while (!in_ready);
    sent_cnt = sent_cnt + 1;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_req(ActByte, s[i]);
  endtask

  // stop sending until every queued result has been taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // one json-like fragment with random content, now and then noise
  task automatic send_fragment();
    int n;
    logic [7:0] ch;
    case ($urandom_range(0, 11))
      0, 1: begin
        // quoted string, escapes included, sometimes left open
        send_req(ActByte, ChQuote);
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 5) == 0) begin
            send_req(ActByte, ChBslash);
            send_req(ActByte, 8'($urandom_range(0, 255)));
          end else begin
            ch = 8'($urandom_range(0, 255));
            if (ch == ChQuote || ch == ChBslash) ch = 8'h61;
            send_req(ActByte, ch);
          end
        end
        if ($urandom_range(0, 9) != 0) send_req(ActByte, ChQuote);
      end
      2, 3: begin
        // number, optional sign and fraction
        if ($urandom_range(0, 2) == 0) send_req(ActByte, ChMinus);
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) send_req(ActByte, 8'(ChZero + $urandom_range(0, 9)));
        if ($urandom_range(0, 2) == 0) begin
          send_req(ActByte, ChDot);
          send_req(ActByte, 8'(ChZero + $urandom_range(0, 9)));
        end
      end
      4, 5, 6: begin
        case ($urandom_range(0, 6))
          0: ch = ChLBrace;
          1: ch = ChRBrace;
          2: ch = ChLBrack;
          3: ch = ChRBrack;
          4: ch = ChComma;
          5: ch = ChColon;
          default: ch = ChQuote;
        endcase
        send_req(ActByte, ch);
      end
      7: begin
        case ($urandom_range(0, 3))
          0: ch = ChSpace;
          1: ch = ChTab;
          2: ch = ChCr;
          default: ch = ChLf;
        endcase
        send_req(ActByte, ch);
      end
      8: begin
        // literal words merge into the token before them
        case ($urandom_range(0, 2))
          0: send_text("true");
          1: send_text("false");
          default: send_text("null");
        endcase
      end
      9, 10: send_req(ActByte, 8'($urandom_range(0, 255)));
      default: begin
        // now and then an end of document with garbage in the char field, else a random byte
        if ($urandom_range(0, 2) == 0) send_req(ActEnd, 8'($urandom_range(0, 255)));
        else send_req(ActByte, 8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  task automatic run_phase(input int snd_pct, input int rcv_pct);
    int target;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    target = sent_cnt + PhaseItems;
    while (sent_cnt < target) send_fragment();
    wait_drained();
  endtask

  initial begin
    in_valid      = 1'b0;
    in_req        = '0;
    rst_n         = 1'b0;
    sent_cnt      = 0;
    send_idle_pct = 36;
    recv_idle_pct = 47;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty end right after reset, char field all ones
    send_req(ActEnd, 8'hff);
    // escaped quote inside a string, signed fraction, dropped space, merged letter
    send_text("{\"a\\\"b\":-1.5 ,x}");
    // extreme bytes are plain symbol bytes
    send_req(ActByte, 8'h00);
    send_req(ActByte, 8'hff);
    // tab, cr and lf, dropped as whitespace, then a bracket
    send_req(ActByte, ChTab);
    send_req(ActByte, ChCr);
    send_req(ActByte, ChLf);
    send_req(ActByte, ChLBrack);
    // end inside an open string
    send_req(ActByte, ChQuote);
    send_req(ActEnd, 8'h00);

    // sender holds off until all directed results are back
    wait_drained();

    run_phase(36, 47);
    run_phase(47, 36);
    run_phase(0, 0);

    // latency tail
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/jts_pkg.sv
design/json_token_splitter.sv
tb/sv/json_token_splitter_checker.sv
tb/sv/json_token_splitter_tb.sv
